/* rtl/core/rar_pkg.sv */
package rar_pkg;

  // Action codes
  localparam logic [2:0] ACT_REDUCE = 3'd0;
  localparam logic [2:0] ACT_NEGATE = 3'd1;
  localparam logic [2:0] ACT_ADD    = 3'd2;
  localparam logic [2:0] ACT_MUL    = 3'd3;
  localparam logic [2:0] ACT_CMP    = 3'd4;

  // Status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZDEN = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  // Fixed field widths
  localparam int FIELD_W = 32;
  localparam int DEN_W   = 31;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_EVAL,
    S_GCD2,
    S_GCD,
    S_DIVN,
    S_DIVD,
    S_FIN,
    S_OUT
  } rar_state_t;

  // Divider status back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } rar_div_stat_t;

endpackage

/* rtl/core/rar_if.sv */
interface rar_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [31:0] a_num;
  logic [31:0] a_den;
  logic [31:0] b_num;
  logic [31:0] b_den;

  modport source (output valid, action, a_num, a_den, b_num, b_den, input ready);
  modport sink   (input valid, action, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rar_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] res_num;
  logic [30:0] res_den;
  logic        is_less;
  logic [1:0]  status;

  modport source (output valid, res_num, res_den, is_less, status, input ready);
  modport sink   (input valid, res_num, res_den, is_less, status, output ready);
endinterface

/* rtl/core/rational_add_mul_reduce_top.sv */
// Rational fraction unit: reduce, negate, add, multiply or compare fractions.
// Input channel in_ch carries an action and two fractions a_num/a_den and
// b_num/b_den; only the low WIDTH bits of each field are used. Output channel
// out_ch returns one item per input item: the reduced fraction (denominator
// positive, zero as 0/1), the compare flag and a status (ok, zero
// denominator, overflow).
// One item is worked at a time; in_ch.ready is high only while idle.
// Steps: up to three products on one shared WIDTH x WIDTH multiplier, an
// evaluation step, a binary gcd on 2*WIDTH-bit magnitudes (one shift or
// subtract per cycle), then two bit-serial divisions on one shared divider,
// then a finish step and a hand-off step. Compare, unknown-action, zero
// numerator and error cases skip the gcd and divisions.
// The result sits in an output register; the next item is taken while it
// waits. If out_ch stalls, the next result waits in the hand-off state and
// in_ch.ready stays low.
// Reset (synchronous, active low) returns to idle and drops out_ch.valid.
module rational_add_mul_reduce_top #(
  parameter int WIDTH = 32
) (
  input  logic clk,
  input  logic rst_n,
  rar_in_if.sink    in_ch,
  rar_out_if.source out_ch
);
  import rar_pkg::*;

  localparam int DW = 2 * WIDTH;
  localparam int KW = $clog2(DW + 1);
  localparam logic [DW-1:0] LIMIT  = DW'(1) << (WIDTH - 1);
  localparam logic [DW-1:0] MAXPOS = LIMIT - DW'(1);

  rar_state_t state_r, state_nxt;

  logic [2:0]       act_r;
  logic             an_neg_r, ad_neg_r, bn_neg_r, bd_neg_r;
  logic [WIDTH-1:0] an_mag_r, ad_mag_r, bn_mag_r, bd_mag_r;
  logic             t_neg_r, num_neg_r, den_neg_r;
  logic [DW-1:0]    t_mag_r, num_mag_r, den_mag_r;
  logic [DW-1:0]    x_r, y_r, g_r, nq_r, dq_r;
  logic [KW-1:0]    k_r;

  logic [FIELD_W-1:0] res_num_r;
  logic [DEN_W-1:0]   res_den_r;
  logic               res_less_r;
  logic [1:0]         res_status_r;

  logic               out_valid_r;
  logic [FIELD_W-1:0] out_num_r;
  logic [DEN_W-1:0]   out_den_r;
  logic               out_less_r;
  logic [1:0]         out_status_r;

  logic [WIDTH-1:0] mul_a, mul_b;
  logic [DW-1:0]    mul_p;
  logic             mul_neg;

  logic             div_start;
  logic [DW-1:0]    div_dividend, div_divisor, div_q;
  rar_div_stat_t    div_stat;

  logic             accept, out_free;
  logic [DW-1:0]    g_now;

  function automatic logic sgn(input logic [31:0] v);
    return v[WIDTH-1];
  endfunction

  function automatic logic [WIDTH-1:0] mag(input logic [31:0] v);
    logic [WIDTH-1:0] f;
    f = v[WIDTH-1:0];
    return f[WIDTH-1] ? (~f + 1'b1) : f;
  endfunction

  function automatic logic [FIELD_W-1:0] enc(input logic neg, input logic [DW-1:0] m);
    logic [FIELD_W-1:0] v;
    v = FIELD_W'(m[WIDTH-1:0]);
    return neg ? (~v + 1'b1) : v;
  endfunction

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign g_now    = y_r << k_r;

  // Shared multiplier operand select
  always_comb begin
    case (state_r)
      S_MUL0: begin
        mul_a   = an_mag_r;
        mul_b   = (act_r == ACT_MUL) ? bn_mag_r : bd_mag_r;
        mul_neg = an_neg_r ^ ((act_r == ACT_MUL) ? bn_neg_r : bd_neg_r);
      end
      S_MUL1: begin
        mul_a   = bn_mag_r;
        mul_b   = ad_mag_r;
        mul_neg = bn_neg_r ^ ad_neg_r;
      end
      default: begin
        mul_a   = ad_mag_r;
        mul_b   = bd_mag_r;
        mul_neg = ad_neg_r ^ bd_neg_r;
      end
    endcase
    mul_p = DW'(mul_a) * DW'(mul_b);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (accept) begin
        if (in_ch.action == ACT_ADD || in_ch.action == ACT_MUL ||
            in_ch.action == ACT_CMP) begin
          state_nxt = S_MUL0;
        end else begin
          state_nxt = S_EVAL;
        end
      end
      S_MUL0: state_nxt = (act_r == ACT_MUL) ? S_MUL2 : S_MUL1;
      S_MUL1: state_nxt = (act_r == ACT_CMP) ? S_EVAL : S_MUL2;
      S_MUL2: state_nxt = S_EVAL;
      S_EVAL: begin
        if (act_r > ACT_CMP || act_r == ACT_CMP || den_mag_r == '0 ||
            num_mag_r == '0) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_GCD2;
        end
      end
      S_GCD2: if (x_r[0] || y_r[0]) state_nxt = S_GCD;
      S_GCD:  if (x_r == '0) state_nxt = S_DIVN;
      S_DIVN: if (div_stat.done) state_nxt = S_DIVD;
      S_DIVD: if (div_stat.done) state_nxt = S_FIN;
      S_FIN:  state_nxt = S_OUT;
      S_OUT:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_ch.ready  = (state_r == S_IDLE);
    div_start    = 1'b0;
    div_dividend = num_mag_r;
    div_divisor  = g_now;
    case (state_r)
      S_GCD: div_start = (x_r == '0);
      S_DIVN: begin
        div_start    = div_stat.done;
        div_dividend = den_mag_r;
        div_divisor  = g_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: if (accept) begin
        act_r    <= in_ch.action;
        an_neg_r <= sgn(in_ch.a_num);
        ad_neg_r <= sgn(in_ch.a_den);
        bn_neg_r <= sgn(in_ch.b_num);
        bd_neg_r <= sgn(in_ch.b_den);
        an_mag_r <= mag(in_ch.a_num);
        ad_mag_r <= mag(in_ch.a_den);
        bn_mag_r <= mag(in_ch.b_num);
        bd_mag_r <= mag(in_ch.b_den);
        num_mag_r <= DW'(mag(in_ch.a_num));
        den_mag_r <= DW'(mag(in_ch.a_den));
        den_neg_r <= sgn(in_ch.a_den);
        // negate flips the sign of a nonzero numerator
        num_neg_r <= sgn(in_ch.a_num) ^
                     ((in_ch.action == ACT_NEGATE) && (mag(in_ch.a_num) != '0));
      end
      S_MUL0: begin
        if (act_r == ACT_MUL) begin
          num_mag_r <= mul_p;
          num_neg_r <= mul_neg && (mul_p != '0);
        end else begin
          t_mag_r <= mul_p;
          t_neg_r <= mul_neg && (mul_p != '0);
        end
      end
      S_MUL1: begin
        if (act_r == ACT_CMP) begin
          num_mag_r <= mul_p;
        end else if (t_neg_r == (mul_neg && (mul_p != '0))) begin
          num_mag_r <= t_mag_r + mul_p;
          num_neg_r <= t_neg_r && ((t_mag_r + mul_p) != '0);
        end else if (t_mag_r >= mul_p) begin
          num_mag_r <= t_mag_r - mul_p;
          num_neg_r <= t_neg_r && (t_mag_r != mul_p);
        end else begin
          num_mag_r <= mul_p - t_mag_r;
          num_neg_r <= !t_neg_r;
        end
      end
      S_MUL2: begin
        den_mag_r <= mul_p;
        den_neg_r <= mul_neg;
      end
      S_EVAL: begin
        res_num_r    <= '0;
        res_den_r    <= '0;
        res_less_r   <= 1'b0;
        res_status_r <= ST_OK;
        x_r <= num_mag_r;
        y_r <= den_mag_r;
        k_r <= '0;
        if (act_r == ACT_CMP) begin
          if (ad_mag_r == '0 || bd_mag_r == '0) begin
            res_status_r <= ST_ZDEN;
          end else begin
            // a*|b_den|*sign vs b*|a_den|*sign, both denominators positive
            if (((an_neg_r ^ ad_neg_r) && t_mag_r != '0) !=
                ((bn_neg_r ^ bd_neg_r) && num_mag_r != '0)) begin
              res_less_r <= (an_neg_r ^ ad_neg_r) && t_mag_r != '0;
            end else if ((an_neg_r ^ ad_neg_r) && t_mag_r != '0) begin
              res_less_r <= t_mag_r > num_mag_r;
            end else begin
              res_less_r <= t_mag_r < num_mag_r;
            end
          end
        end else if (act_r > ACT_CMP) begin
          res_status_r <= ST_OK;
        end else if (den_mag_r == '0) begin
          res_status_r <= ST_ZDEN;
          if (num_neg_r) begin
            res_num_r <= enc(1'b1, (num_mag_r > LIMIT) ? LIMIT : num_mag_r);
          end else begin
            res_num_r <= enc(1'b0, (num_mag_r > MAXPOS) ? MAXPOS : num_mag_r);
          end
        end else if (num_mag_r == '0) begin
          res_den_r <= DEN_W'(1);
        end
      end
      // strip common factors of two
      S_GCD2: if (!x_r[0] && !y_r[0]) begin
        x_r <= x_r >> 1;
        y_r <= y_r >> 1;
        k_r <= k_r + 1'b1;
      end
      S_GCD: begin
        if (x_r == '0) begin
          g_r <= g_now;
        end else if (!x_r[0]) begin
          x_r <= x_r >> 1;
        end else if (!y_r[0]) begin
          y_r <= y_r >> 1;
        end else if (x_r >= y_r) begin
          x_r <= x_r - y_r;
        end else begin
          y_r <= y_r - x_r;
        end
      end
      S_DIVN: if (div_stat.done) nq_r <= div_q;
      S_DIVD: if (div_stat.done) dq_r <= div_q;
      S_FIN: begin
        res_less_r <= 1'b0;
        if (dq_r > MAXPOS || nq_r > ((num_neg_r ^ den_neg_r) ? LIMIT : MAXPOS)) begin
          res_num_r    <= '0;
          res_den_r    <= '0;
          res_status_r <= ST_OVF;
        end else begin
          res_num_r    <= enc(num_neg_r ^ den_neg_r, nq_r);
          res_den_r    <= DEN_W'(dq_r);
          res_status_r <= ST_OK;
        end
      end
      default: ;
    endcase
  end

  rar_div #(.DW(DW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quotient (div_q)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && out_free) begin
      out_num_r    <= res_num_r;
      out_den_r    <= res_den_r;
      out_less_r   <= res_less_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.res_num = out_num_r;
  assign out_ch.res_den = out_den_r;
  assign out_ch.is_less = out_less_r;
  assign out_ch.status  = out_status_r;

endmodule

/* rtl/core/rar_div.sv */
module rar_div #(
  parameter int DW = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [DW-1:0]          dividend,
  input  logic [DW-1:0]          divisor,
  output rar_pkg::rar_div_stat_t stat,
  output logic [DW-1:0]          quotient
);
  import rar_pkg::*;

  localparam int CW = $clog2(DW + 1);

  logic [DW:0]   rem_r;
  logic [DW-1:0] quo_r;
  logic [DW-1:0] dvs_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;

  logic [DW:0]   rem_sh;
  logic [DW:0]   rem_sub;
  logic          take;

  // One quotient bit per cycle, restoring
  always_comb begin
    rem_sh  = {rem_r[DW-1:0], quo_r[DW-1]};
    rem_sub = rem_sh - {1'b0, dvs_r};
    take    = rem_sh >= {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= take ? rem_sub : rem_sh;
      quo_r <= {quo_r[DW-2:0], take};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

/* rtl/core/rar_chk.sv */
module rar_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] res_num,
  input logic [30:0] res_den,
  input logic        is_less,
  input logic [1:0]  status
);
  import rar_pkg::*;

  // a stalled item stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out item dropped while stalled");

  // zero denominator always reports a zero denominator
  a_zden: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_ZDEN |-> res_den == '0 && !is_less)
    else $error("zero-denominator item carries a denominator");

  // overflow clears the fraction
  a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_OVF |-> res_num == '0 && res_den == '0 && !is_less)
    else $error("overflow item not cleared");

  // compare results carry no fraction
  a_less: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && is_less |-> status == ST_OK && res_num == '0 && res_den == '0)
    else $error("compare item carries a fraction");

endmodule

bind rational_add_mul_reduce_top rar_chk u_rar_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .res_num   (out_ch.res_num),
  .res_den   (out_ch.res_den),
  .is_less   (out_ch.is_less),
  .status    (out_ch.status)
);
